@@ hdl/vgpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgpd_pkg
// Shared constants, register codes and controller/datapath interface types
// for the voxel grid point deduplicator.
// ----------------------------------------------------------------------------
package vgpd_pkg;

	// occupancy bitmap geometry: rows of 32 cells, each row tagged with an epoch
	localparam int GRID_DEPTH = 2097152;
	localparam int ROW_BITS   = 5;
	localparam int ROW_CELLS  = 1 << ROW_BITS;
	localparam int ROWS       = (GRID_DEPTH + ROW_CELLS - 1) / ROW_CELLS;
	localparam int ADDR_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int TAG_W      = 8;
	localparam int ROW_W      = TAG_W + ROW_CELLS;
	localparam logic [TAG_W-1:0] EPOCH_MAX   = '1;
	localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);

	// linear cell index width, covers the largest grid depth
	localparam int IDX_W = 25;

	// configuration port
	localparam int CFG_W = 16;

	typedef enum logic [2:0] {
		CFG_EMIT_MID  = 3'd0,
		CFG_X_SCALE   = 3'd1,
		CFG_Y_SCALE   = 3'd2,
		CFG_Z_SCALE   = 3'd3,
		CFG_X_HALF    = 3'd4,
		CFG_Y_HALF    = 3'd5,
		CFG_Z_CELLS   = 3'd6
	} cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture input word
		logic s1_en;       // products
		logic s2_en;       // cells and box test
		logic s3_en;       // index partial products
		logic s4_en;       // linear index
		logic rd;          // bitmap row read
		logic mark;        // set cell bit in row
		logic div_start;   // start midpoint dividers
		logic emit;        // load output register
		logic clr_wr;      // clearing pass write
		logic epoch_bump;  // next cloud
		logic epoch_reset; // after clearing pass
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_box;
		logic keep;
		logic emit_mid;
		logic div_busy;
		logic out_free;
		logic clr_last;
		logic epoch_full;
	} sts_t;

endpackage : vgpd_pkg
`default_nettype wire

@@ hdl/vgpd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgpd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vgpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : vgpd_ram
`default_nettype wire

@@ hdl/vgpd_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgpd_div
// Restoring divider, one quotient bit a cycle: (mag * 2^24) / scale,
// truncated, negated for a negative cell; zero for a zero scale.
// ----------------------------------------------------------------------------
module vgpd_div
	import vgpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [6:0]  mag,
	input  wire logic        neg,
	input  wire logic [15:0] scale,
	output logic             busy,
	output logic [31:0]      quot
);

	localparam int QW = 31;

	logic [15:0]   rem_q;
	logic [QW-1:0] dvd_q;
	logic [QW-1:0] quo_q;
	logic [4:0]    cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic [16:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, dvd_q[QW-1]};
	assign fits    = (shifted >= {1'b0, scale});

	// one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(QW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {mag, 24'b0};
			quo_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(shifted - {1'b0, scale}) : shifted[15:0];
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = (scale == 16'd0) ? 32'd0 :
		(neg_q ? 32'(-{1'b0, quo_q}) : {1'b0, quo_q});

endmodule : vgpd_div
`default_nettype wire

@@ hdl/vgpd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgpd_datapath
// Configuration registers, cell arithmetic stages, epoch-tagged occupancy
// bitmap, midpoint dividers and output register.
// ----------------------------------------------------------------------------
module vgpd_datapath
	import vgpd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic [95:0]       in_data,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [95:0]            out_data
);

	// configuration
	logic        emit_mid_q;
	logic [15:0] x_scale_q, y_scale_q, z_scale_q;
	logic [5:0]  x_half_q, y_half_q;
	logic [6:0]  z_cells_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_mid_q <= 1'b0;
			x_scale_q  <= 16'd2560;
			y_scale_q  <= 16'd2560;
			z_scale_q  <= 16'd2560;
			x_half_q   <= 6'd20;
			y_half_q   <= 6'd20;
			z_cells_q  <= 7'd40;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EMIT_MID: emit_mid_q <= cfg_data[0];
				CFG_X_SCALE:  x_scale_q  <= cfg_data;
				CFG_Y_SCALE:  y_scale_q  <= cfg_data;
				CFG_Z_SCALE:  z_scale_q  <= cfg_data;
				CFG_X_HALF:   x_half_q   <= cfg_data[5:0];
				CFG_Y_HALF:   y_half_q   <= cfg_data[5:0];
				CFG_Z_CELLS:  z_cells_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input capture
	logic signed [31:0] x_q, y_q, z_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= in_data[31:0];
			y_q <= in_data[63:32];
			z_q <= in_data[95:64];
		end
	end

	// stage 1: coordinate times scale, Q.24
	logic signed [48:0] px_s1, py_s1, pz_s1;
	always_ff @(posedge clk) begin
		if (cmd.s1_en) begin
			px_s1 <= 49'(x_q) * 49'($signed({1'b0, x_scale_q}));
			py_s1 <= 49'(y_q) * 49'($signed({1'b0, y_scale_q}));
			pz_s1 <= 49'(z_q) * 49'($signed({1'b0, z_scale_q}));
		end
	end

	// rounded magnitude, half away from zero
	function automatic logic [23:0] cell_mag(input logic signed [48:0] p);
		logic [48:0] m;
		m = p[48] ? 49'(-p) : p;
		return 24'((m + 49'(24'h800000)) >> 24);
	endfunction

	logic [23:0] xm, ym, zm;
	logic        box;
	assign xm  = cell_mag(px_s1);
	assign ym  = cell_mag(py_s1);
	assign zm  = cell_mag(pz_s1);
	assign box = (xm <= 24'(x_half_q)) && (ym <= 24'(y_half_q)) &&
		(zm <= 24'(z_cells_q)) && (!pz_s1[48] || zm == 24'd0);

	// stage 2: cells and box test
	logic [6:0] xmag_s2, ymag_s2, zmag_s2;
	logic       xneg_s2, yneg_s2, zneg_s2, box_s2;
	always_ff @(posedge clk) begin
		if (cmd.s2_en) begin
			xmag_s2 <= xm[6:0];
			ymag_s2 <= ym[6:0];
			zmag_s2 <= zm[6:0];
			xneg_s2 <= px_s1[48];
			yneg_s2 <= py_s1[48];
			zneg_s2 <= pz_s1[48];
			box_s2  <= box;
		end
	end

	// stage 3: row widths and offsets
	logic [6:0]  xw, yw, xd, yd;
	logic [13:0] xwyw_s3, ymul_s3;
	logic [6:0]  xoff_s3, zc_s3;
	assign xw = {x_half_q, 1'b1};
	assign yw = {y_half_q, 1'b1};
	assign xd = xneg_s2 ? 7'({1'b0, x_half_q} + xmag_s2) : 7'({1'b0, x_half_q} - xmag_s2);
	assign yd = yneg_s2 ? 7'({1'b0, y_half_q} + ymag_s2) : 7'({1'b0, y_half_q} - ymag_s2);

	always_ff @(posedge clk) begin
		if (cmd.s3_en) begin
			xwyw_s3 <= 14'(xw) * 14'(yw);
			ymul_s3 <= 14'(yd) * 14'(xw);
			xoff_s3 <= xd;
			zc_s3   <= zmag_s2;
		end
	end

	// stage 4: linear index
	logic [20:0]      zprod;
	logic [IDX_W-1:0] idx_s4;
	assign zprod = 21'(zc_s3) * 21'(xwyw_s3);
	always_ff @(posedge clk) begin
		if (cmd.s4_en) begin
			idx_s4 <= IDX_W'(zprod) + IDX_W'(ymul_s3) + IDX_W'(xoff_s3);
		end
	end

	// epoch and clearing counter
	logic [TAG_W-1:0]  epoch_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clr_last;
	assign clr_last = (clr_cnt_q == ADDR_W'(ROWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= EPOCH_FIRST;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.epoch_reset) begin
				epoch_q <= EPOCH_FIRST;
			end else if (cmd.epoch_bump) begin
				epoch_q <= epoch_q + TAG_W'(1);
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + ADDR_W'(1);
			end
		end
	end

	// bitmap rows: tag plus 32 cells; a stale tag reads as empty
	logic [ROW_W-1:0]     rdata, wdata;
	logic [ADDR_W-1:0]    row, waddr;
	logic [ROW_CELLS-1:0] cells, bitsel;
	logic                 fresh, hit, in_depth;

	assign row      = idx_s4[ADDR_W+ROW_BITS-1:ROW_BITS];
	assign fresh    = (rdata[ROW_W-1:ROW_CELLS] == epoch_q);
	assign cells    = fresh ? rdata[ROW_CELLS-1:0] : '0;
	assign bitsel   = ROW_CELLS'(1) << idx_s4[ROW_BITS-1:0];
	assign hit      = |(cells & bitsel);
	assign in_depth = (idx_s4 < IDX_W'(GRID_DEPTH));
	assign waddr    = cmd.clr_wr ? clr_cnt_q : row;
	assign wdata    = cmd.clr_wr ? '0 : {epoch_q, cells | bitsel};

	vgpd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_bitmap (
		.clk   (clk),
		.we    (cmd.clr_wr | cmd.mark),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (row),
		.rdata (rdata)
	);

	// midpoint dividers, one per axis
	logic [31:0] qx, qy, qz;
	logic        bx, by, bz;

	vgpd_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .mag(xmag_s2),
		.neg(xneg_s2), .scale(x_scale_q), .busy(bx), .quot(qx)
	);
	vgpd_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .mag(ymag_s2),
		.neg(yneg_s2), .scale(y_scale_q), .busy(by), .quot(qy)
	);
	vgpd_div u_div_z (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .mag(zmag_s2),
		.neg(zneg_s2), .scale(z_scale_q), .busy(bz), .quot(qz)
	);

	// output register
	logic        out_valid_q;
	logic [95:0] out_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= emit_mid_q ? {qz, qy, qx} : {z_q, y_q, x_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// status
	assign sts.in_box     = box_s2;
	assign sts.keep       = in_depth && !hit;
	assign sts.emit_mid   = emit_mid_q;
	assign sts.div_busy   = bx | by | bz;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.clr_last   = clr_last;
	assign sts.epoch_full = (epoch_q == EPOCH_MAX);

endmodule : vgpd_datapath
`default_nettype wire

@@ hdl/vgpd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgpd_ctrl
// Sequencer: clearing pass, accept, arithmetic stages, bitmap test and set,
// midpoint division and hand-off to the output register.
// ----------------------------------------------------------------------------
module vgpd_ctrl
	import vgpd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  start_of_cloud,
	input  wire logic  point_valid,
	output logic       in_ready,
	input  wire sts_t  sts,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_SWEEP, ST_IDLE, ST_MUL, ST_CELL, ST_IDX1, ST_IDX2,
		ST_READ, ST_TEST, ST_DIV, ST_EMIT
	} state_t;

	state_t state_q;
	logic   resume_q;  // carry on with the point after a wrap clear
	logic   take;

	assign take     = in_valid && (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			resume_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_SWEEP: if (sts.clr_last) state_q <= resume_q ? ST_MUL : ST_IDLE;
				ST_IDLE: begin
					if (take) begin
						if (start_of_cloud && sts.epoch_full) begin
							state_q  <= ST_SWEEP;
							resume_q <= point_valid;
						end else begin
							state_q <= point_valid ? ST_MUL : ST_IDLE;
						end
					end
				end
				ST_MUL:  state_q <= ST_CELL;
				ST_CELL: state_q <= ST_IDX1;
				ST_IDX1: state_q <= sts.in_box ? ST_IDX2 : ST_IDLE;
				ST_IDX2: state_q <= ST_READ;
				ST_READ: state_q <= ST_TEST;
				ST_TEST: begin
					if (!sts.keep) state_q <= ST_IDLE;
					else state_q <= sts.emit_mid ? ST_DIV : ST_EMIT;
				end
				ST_DIV:  if (!sts.div_busy) state_q <= ST_EMIT;
				ST_EMIT: if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd             = '0;
		cmd.load        = take;
		cmd.epoch_bump  = take && start_of_cloud && !sts.epoch_full;
		cmd.clr_wr      = (state_q == ST_SWEEP);
		cmd.epoch_reset = (state_q == ST_SWEEP) && sts.clr_last;
		cmd.s1_en       = (state_q == ST_MUL);
		cmd.s2_en       = (state_q == ST_CELL);
		cmd.s3_en       = (state_q == ST_IDX1);
		cmd.s4_en       = (state_q == ST_IDX2);
		cmd.rd          = (state_q == ST_READ);
		cmd.mark        = (state_q == ST_TEST) && sts.keep;
		cmd.div_start   = (state_q == ST_TEST) && sts.keep && sts.emit_mid;
		cmd.emit        = (state_q == ST_EMIT) && sts.out_free;
	end

endmodule : vgpd_ctrl
`default_nettype wire

@@ hdl/voxel_grid_point_dedup_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_grid_point_dedup_top
// Voxel grid downsampler: keeps the first point that lands in each cell.
// ----------------------------------------------------------------------------
// Input stream s_*: one point per word, tuser carries the start-of-cloud and
// point-valid flags. Output stream m_*: one word per first hit in a cell,
// either the original point or the cell midpoint (register CFG_EMIT_MID).
// Configuration is a plain write port; the user must write it only while
// the block is idle, which the block does not enforce. One point at a time:
// accept, 3 arithmetic stages, index, bitmap read, test-and-set, then
// output; a point outside the box ends at the box test, one whose cell is
// taken at the test. Midpoint mode adds a wait for the bit-serial dividers.
// Occupancy lives in a RAM of 32-cell rows tagged with a cloud epoch, so a
// new cloud costs nothing, except every 255th cloud, which runs a clearing
// pass over all GRID_DEPTH/32 rows (65536) before the point is handled. The
// same pass runs after reset; tready stays low meanwhile. A result waits in
// the output register while m_tready is low; the next point is accepted and
// stalls only at its own output step.
// ----------------------------------------------------------------------------
module voxel_grid_point_dedup_top
	import vgpd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// input points
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [95:0]       s_tdata,  // in_x, in_y, in_z
	input  wire logic [1:0]        s_tuser,  // start_of_cloud, point_valid
	// output points
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [95:0]            m_tdata   // out_x, out_y, out_z
);

	cmd_t cmd;
	sts_t sts;

	vgpd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.start_of_cloud (s_tuser[0]),
		.point_valid    (s_tuser[1]),
		.in_ready       (s_tready),
		.sts            (sts),
		.cmd            (cmd)
	);

	vgpd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule : voxel_grid_point_dedup_top
`default_nettype wire

@@ dv/voxel_grid_point_dedup_top_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_grid_point_dedup_top_test
// Self-checking bench for the voxel grid downsampler: directed table, then
// random clouds under several register settings, with random gaps on both
// streams and one long output hold-off; every word is checked against the
// table's expectation or a local occupancy model.
// ----------------------------------------------------------------------------
module voxel_grid_point_dedup_top_test;
	import vgpd_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;

	voxel_grid_point_dedup_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local register copy and occupancy
	bit          mid_mode;
	bit [15:0]   scl [3];
	int          xh, yh, zmax;
	bit          occ [int];

	logic [95:0] pending_points[$];
	int          errors = 0;
	int          n_sent = 0, n_kept = 0, n_dropped = 0;
	longint      cycles = 0;
	int          hold_off = 0;
	bit          hold_req = 1'b0;

	function automatic longint cell_of(logic signed [31:0] c, bit [15:0] s);
		longint prod, mag, r;
		prod = longint'(c) * longint'({1'b0, s});
		mag  = prod < 0 ? -prod : prod;
		r    = (mag + (64'sd1 << 23)) >>> 24;
		return prod < 0 ? -r : r;
	endfunction

	function automatic logic [31:0] mid_of(longint cidx, bit [15:0] s);
		longint mag, q;
		if (s == 0)
			return '0;
		mag = cidx < 0 ? -cidx : cidx;
		q   = (mag << 24) / longint'({1'b0, s});
		if (cidx < 0)
			q = -q;
		return q[31:0];
	endfunction

	// returns 1 and the expected word on a first hit
	function automatic bit dedup_point(bit soc, bit vld, logic [95:0] p,
			output logic [95:0] res);
		longint xc, yc, zc, idx;
		res = '0;
		if (soc)
			occ.delete();
		if (!vld)
			return 0;
		xc = cell_of(p[31:0], scl[0]);
		yc = cell_of(p[63:32], scl[1]);
		zc = cell_of(p[95:64], scl[2]);
		if (xc > xh || xc < -xh || yc > yh || yc < -yh || zc > zmax || zc < 0)
			return 0;
		idx = zc * (2*xh+1) * (2*yh+1) + (yh - yc) * (2*xh+1) + (xh - xc);
		if (idx >= GRID_DEPTH || occ.exists(int'(idx)))
			return 0;
		occ[int'(idx)] = 1'b1;
		if (mid_mode)
			res = {mid_of(zc, scl[2]), mid_of(yc, scl[1]), mid_of(xc, scl[0])};
		else
			res = p;
		return 1;
	endfunction

	task automatic write_reg(cfg_idx_t i, int v);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= i; cfg_data <= v[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (i)
			CFG_EMIT_MID: mid_mode = v[0];
			CFG_X_SCALE:  scl[0] = v[15:0];
			CFG_Y_SCALE:  scl[1] = v[15:0];
			CFG_Z_SCALE:  scl[2] = v[15:0];
			CFG_X_HALF:   xh = v & 6'h3f;
			CFG_Y_HALF:   yh = v & 6'h3f;
			CFG_Z_CELLS:  zmax = v & 7'h7f;
			default: ;
		endcase
	endtask

	// send one word; expectation is queued when the word is accepted.
	// exp: -1 take the predictor, 0 no word, 1 the point itself
	task automatic send_point(bit soc, bit vld, logic [95:0] p, bit gaps, int exp);
		logic [95:0] res;
		bit          kept;
		int          gap;
		gap = gaps ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1; s_tuser <= {vld, soc}; s_tdata <= p;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		kept = dedup_point(soc, vld, p, res);
		if (exp >= 0) begin
			kept = (exp != 0);
			res  = p;
		end
		if (kept) begin
			pending_points = {pending_points, res};
			n_kept++;
		end else
			n_dropped++;
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// coordinate near a chosen cell, with random jitter
	function automatic logic [31:0] near_cell(int cidx, bit [15:0] s);
		longint base;
		if (s == 0)
			return $urandom;
		base = (longint'(cidx) << 24) / longint'({1'b0, s});
		return base[31:0] + ($urandom_range(0, 32'h1fff) - 32'h1000);
	endfunction

	function automatic logic [95:0] random_point();
		logic [95:0] p;
		if ($urandom_range(0, 9) < 8) begin
			p[31:0]  = near_cell($urandom_range(0, 2*xh+2) - xh - 1, scl[0]);
			p[63:32] = near_cell($urandom_range(0, 2*yh+2) - yh - 1, scl[1]);
			p[95:64] = near_cell($urandom_range(0, zmax+1) - 1, scl[2]);
		end else
			p = {$urandom, $urandom, $urandom};
		return p;
	endfunction

	// receiver: random wait per word, one long hold-off on request
	initial begin : receiver
		int n;
		bit held;
		held = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				hold_off = 400;
				while (hold_off > 0) begin
					@(negedge clk);
					hold_off--;
				end
			end
			n = $urandom_range(0, 17);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// output checker
	always @(posedge clk) begin
		logic [95:0] want;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word %h", m_tdata);
			end else begin
				want = pending_points.pop_front();
				if (want !== m_tdata) begin
					errors++;
					if (errors <= 10)
						$display("mismatch x %h/%h y %h/%h z %h/%h (exp/got)",
							want[31:0], m_tdata[31:0], want[63:32], m_tdata[63:32],
							want[95:64], m_tdata[95:64]);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d words outstanding", pending_points.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	typedef struct {
		bit soc;
		bit vld;
		logic [31:0] x, y, z;
		int exp;
	} stim_row_t;

	stim_row_t directed [] = '{
		'{1, 1, 32'h0, 32'h0, 32'h0, 1},                // origin cell
		'{0, 1, 32'h0, 32'h0, 32'h0, 0},                // same cell: no word
		'{0, 0, 32'h12345, 32'h0, 32'h0, 0},            // missing point
		'{0, 1, 32'h7fffffff, 32'h0, 32'h0, 0},         // far out of box
		'{0, 1, 32'h80000000, 32'h80000000, 32'h80000000, 0},
		'{0, 1, 32'h0, 32'h0, 32'hffff0000, 0},         // z below zero
		'{0, 1, 32'h20000, 32'h0, 32'h0, 1},            // x at the +20 box limit
		'{0, 1, 32'hfffe0000, 32'h0, 32'h0, 1},         // x at the -20 box limit
		'{0, 1, 32'h21000, 32'h0, 32'h0, 0},            // x beyond +20
		'{0, 1, 32'h0, 32'h20000, 32'h40000, 1},        // y and z at their box limits
		'{0, 1, 32'h0cccc, 32'h0, 32'h0, -1},           // rounds up to cell 8
		'{0, 1, 32'hffff3334, 32'h0, 32'h0, -1},        // rounds to cell -8
		'{1, 0, 32'h0, 32'h0, 32'h0, 0},                // clear via missing point
		'{0, 1, 32'h0, 32'h0, 32'h0, 1},                // origin again: new word
		'{0, 1, 32'hffffffff, 32'hffffffff, 32'h0, -1}
	};

	initial begin
		logic [95:0] p;
		mid_mode = 0; scl = '{2560, 2560, 2560}; xh = 20; yh = 20; zmax = 40;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset settings
		foreach (directed[i])
			send_point(directed[i].soc, directed[i].vld,
				{directed[i].z, directed[i].y, directed[i].x}, 1'b0, directed[i].exp);
		drain();

		// midpoints, zero scale on x, full range limits
		write_reg(CFG_EMIT_MID, 1);
		write_reg(CFG_X_SCALE, 0);
		write_reg(CFG_Y_SCALE, 65535);
		write_reg(CFG_Z_SCALE, 1);
		write_reg(CFG_X_HALF, 63);
		write_reg(CFG_Y_HALF, 0);
		write_reg(CFG_Z_CELLS, 127);
		send_point(1, 1, {32'h7fffffff, 32'h0, 32'h12345678}, 1'b0, -1);
		send_point(0, 1, {32'h80000000, 32'h100, 32'h0}, 1'b0, -1);
		send_point(0, 1, {32'h00000000, 32'hffffff00, 32'h0}, 1'b0, -1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_EMIT_MID, 0); write_reg(CFG_X_SCALE, 2560);
					write_reg(CFG_Y_SCALE, 2560); write_reg(CFG_Z_SCALE, 2560);
					write_reg(CFG_X_HALF, 3); write_reg(CFG_Y_HALF, 3);
					write_reg(CFG_Z_CELLS, 3);
				end
				1: begin
					write_reg(CFG_EMIT_MID, 1); write_reg(CFG_X_SCALE, 256);
					write_reg(CFG_Y_SCALE, 65535); write_reg(CFG_Z_SCALE, 777);
					write_reg(CFG_X_HALF, 0); write_reg(CFG_Y_HALF, 63);
					write_reg(CFG_Z_CELLS, 0);
				end
				2: begin
					write_reg(CFG_EMIT_MID, 0); write_reg(CFG_X_SCALE, 1);
					write_reg(CFG_Y_SCALE, 40000); write_reg(CFG_Z_SCALE, 65535);
					write_reg(CFG_X_HALF, 63); write_reg(CFG_Y_HALF, 63);
					write_reg(CFG_Z_CELLS, 127);
				end
				3: begin
					write_reg(CFG_EMIT_MID, 1); write_reg(CFG_X_SCALE, $urandom_range(1, 65535));
					write_reg(CFG_Y_SCALE, $urandom_range(1, 65535));
					write_reg(CFG_Z_SCALE, $urandom_range(1, 65535));
					write_reg(CFG_X_HALF, $urandom_range(0, 6));
					write_reg(CFG_Y_HALF, $urandom_range(0, 6));
					write_reg(CFG_Z_CELLS, $urandom_range(0, 6));
				end
				default: begin
					write_reg(CFG_EMIT_MID, 0); write_reg(CFG_X_SCALE, 2560);
					write_reg(CFG_Y_SCALE, 2560); write_reg(CFG_Z_SCALE, 2560);
					write_reg(CFG_X_HALF, 20); write_reg(CFG_Y_HALF, 20);
					write_reg(CFG_Z_CELLS, 40);
				end
			endcase
			if (ph == 2)
				hold_req = 1'b1;
			for (int k = 0; k < 150; k++) begin
				p = random_point();
				send_point(k == 0 || $urandom_range(0, 39) == 0,
					$urandom_range(0, 9) != 0, p, ph != 4 || k > 60, -1);
			end
			drain();
		end

		$display("sent %0d points: %0d kept, %0d dropped or repeated", n_sent, n_kept,
			n_dropped);
		$display("covered both emit modes, scale and range extremes, cloud restarts");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule : voxel_grid_point_dedup_top_test
`default_nettype wire
